// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the RTL of the argument tokenizer.
// Depends on nothing; taken in by quoted_argument_tokenizer_core, which checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/core/qat_pkg.sv -----
// Package for the argument tokenizer: parse modes, byte codes, result word type.
// Depends on nothing; used by qat_step and quoted_argument_tokenizer_core.
package qat_pkg;

   typedef enum logic [2:0] {
      MODE_START     = 3'd0,
      MODE_LEADWS    = 3'd1,
      MODE_BETWEEN   = 3'd2,
      MODE_TOKEN     = 3'd3,
      MODE_TOKEN_ESC = 3'd4,
      MODE_QUOTE     = 3'd5,
      MODE_QUOTE_ESC = 3'd6,
      MODE_IGNORE    = 3'd7
   } mode_type;

   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;

   localparam logic [7:0] MAX_TOKENS_RESET = 8'd64;

   // Register index as decoded from the byte address
   localparam logic REG_MAX_TOKENS = 1'b0;

   typedef struct packed {
      logic       char_valid;
      logic [7:0] char_out;
      logic       token_end;
      logic [7:0] token_index;
      logic       line_done;
      logic [7:0] token_count;
   } result_type;

endpackage

// ----- rtl/core/qat_step.sv -----
// One byte step of the tokenizer: next parse mode, token count and result word.
// Depends on qat_pkg.
module qat_step (
   input  qat_pkg::mode_type   mode,
   input  logic [7:0]          tokens_seen,
   input  logic [7:0]          max_tokens,
   input  logic [7:0]          byte_in,
   input  logic                line_last,
   output qat_pkg::mode_type   mode_next,
   output logic [7:0]          tokens_next,
   output qat_pkg::result_type result
);

   logic              is_ws;
   logic              is_quote;
   logic              is_bslash;
   logic              at_limit;
   qat_pkg::mode_type mode_step;
   logic              emit;
   logic              step_close;
   logic              last_close;
   logic [7:0]        seen_step;
   logic [7:0]        seen_final;

   assign is_ws     = (byte_in == qat_pkg::CH_SPACE) || (byte_in == qat_pkg::CH_TAB);
   assign is_quote  = (byte_in == qat_pkg::CH_QUOTE);
   assign is_bslash = (byte_in == qat_pkg::CH_BSLASH);
   assign at_limit  = (tokens_seen >= max_tokens);

   // Next state
   always_comb begin
      mode_step  = mode;
      emit       = 1'b0;
      step_close = 1'b0;
      case (mode)
         qat_pkg::MODE_START, qat_pkg::MODE_LEADWS, qat_pkg::MODE_BETWEEN: begin
            if (is_ws) begin
               if (mode == qat_pkg::MODE_START) begin
                  mode_step = qat_pkg::MODE_LEADWS;
               end
            end else if (at_limit) begin
               mode_step = qat_pkg::MODE_IGNORE;
            end else if (is_quote) begin
               mode_step = qat_pkg::MODE_QUOTE;
            end else if (is_bslash) begin
               mode_step = qat_pkg::MODE_TOKEN_ESC;
            end else begin
               mode_step = qat_pkg::MODE_TOKEN;
               emit      = 1'b1;
            end
         end
         qat_pkg::MODE_TOKEN: begin
            if (is_ws) begin
               mode_step  = qat_pkg::MODE_BETWEEN;
               step_close = 1'b1;
            end else if (is_quote) begin
               mode_step = qat_pkg::MODE_QUOTE;
            end else if (is_bslash) begin
               mode_step = qat_pkg::MODE_TOKEN_ESC;
            end else begin
               emit = 1'b1;
            end
         end
         qat_pkg::MODE_TOKEN_ESC: begin
            mode_step = qat_pkg::MODE_TOKEN;
            emit      = 1'b1;
         end
         qat_pkg::MODE_QUOTE: begin
            if (is_quote) begin
               mode_step = qat_pkg::MODE_TOKEN;
            end else if (is_bslash) begin
               mode_step = qat_pkg::MODE_QUOTE_ESC;
            end else begin
               emit = 1'b1;
            end
         end
         qat_pkg::MODE_QUOTE_ESC: begin
            mode_step = qat_pkg::MODE_QUOTE;
            emit      = 1'b1;
         end
         default: begin
            mode_step = mode;
         end
      endcase

      seen_step = tokens_seen + {7'd0, step_close};

      // An open token closes at line end; a whitespace-only line gets one empty token
      last_close = line_last &&
                   ((mode_step inside {qat_pkg::MODE_TOKEN, qat_pkg::MODE_TOKEN_ESC,
                                       qat_pkg::MODE_QUOTE, qat_pkg::MODE_QUOTE_ESC}) ||
                    ((mode_step == qat_pkg::MODE_LEADWS) && !at_limit));

      seen_final  = seen_step + {7'd0, last_close};
      mode_next   = line_last ? qat_pkg::MODE_START : mode_step;
      tokens_next = line_last ? 8'd0 : seen_step;
   end

   // Outputs; at most one close per byte, so a reported index is always the pre-step count
   always_comb begin
      result.char_valid  = emit;
      result.char_out    = emit ? byte_in : 8'd0;
      result.token_end   = step_close || last_close;
      result.token_index = (emit || step_close || last_close) ? tokens_seen : 8'd0;
      result.line_done   = line_last;
      result.token_count = line_last ? seen_final : 8'd0;
   end

endmodule

// ----- rtl/core/quoted_argument_tokenizer_core.sv -----
// Shell-style argument tokenizer, one line byte per word in, one result word out.
// An accepted byte's result word is registered in the output register, or in the skid on a stall.
// Throughput: 1 byte per cycle while req_stall is low; the parse step is one mode/count update.
// A two-entry output (register plus skid) takes one more byte while the output is stalled.
// Reset (synchronous): line start mode, count 0, max_tokens 64, outputs empty.
// Depends on qat_pkg, qat_step and assert_macros.svh.
`include "assert_macros.svh"

module quoted_argument_tokenizer_core (
   input  logic        clock,
   input  logic        reset,
   // byte input
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_byte_in,
   input  logic        req_line_last,
   // result output
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_char_valid,
   output logic [7:0]  rsp_char_out,
   output logic        rsp_token_end,
   output logic [7:0]  rsp_token_index,
   output logic        rsp_line_done,
   output logic [7:0]  rsp_token_count,
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   qat_pkg::mode_type   mode_ff, mode_in;
   logic [7:0]          seen_ff, seen_in;
   logic [7:0]          max_tokens_ff;
   qat_pkg::result_type step_result;
   qat_pkg::result_type out_ff;
   qat_pkg::result_type skid_ff;
   logic                out_valid_ff;
   logic                skid_valid_ff;
   logic                accept;
   logic                out_free;
   logic                csr_write;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign out_free  = !out_valid_ff || !rsp_stall;

   qat_step u_step (
      .mode        (mode_ff),
      .tokens_seen (seen_ff),
      .max_tokens  (max_tokens_ff),
      .byte_in     (req_byte_in),
      .line_last   (req_line_last),
      .mode_next   (mode_in),
      .tokens_next (seen_in),
      .result      (step_result)
   );

   // parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= qat_pkg::MODE_START;
         seen_ff <= 8'd0;
      end else if (accept) begin
         mode_ff <= mode_in;
         seen_ff <= seen_in;
      end
   end

   // output register with skid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= accept;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_ff <= skid_valid_ff ? skid_ff : step_result;
      end
      if (!out_free && accept) begin
         skid_ff <= step_result;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_char_valid  = out_ff.char_valid;
   assign rsp_char_out    = out_ff.char_out;
   assign rsp_token_end   = out_ff.token_end;
   assign rsp_token_index = out_ff.token_index;
   assign rsp_line_done   = out_ff.line_done;
   assign rsp_token_count = out_ff.token_count;

   // configuration
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_tokens_ff <= qat_pkg::MAX_TOKENS_RESET;
      end else if (csr_write && (csr_paddr[2] == qat_pkg::REG_MAX_TOKENS)) begin
         max_tokens_ff <= csr_pwdata[7:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == qat_pkg::REG_MAX_TOKENS) ?
                       {24'd0, max_tokens_ff} : 32'd0;

   `ASSERT_IMPLY(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)
   `ASSERT_NEXT(a_line_end_clears, clock, reset, accept && req_line_last,
                (seen_ff == 8'd0) && (mode_ff == qat_pkg::MODE_START))
   `ASSERT_NEXT(a_skid_moves_up, clock, reset, skid_valid_ff && !rsp_stall,
                out_valid_ff && !skid_valid_ff)
   `ASSERT_IMPLY(a_count_only_at_end, clock, reset, out_valid_ff && !out_ff.line_done,
                 out_ff.token_count == 8'd0)

endmodule
